### hdl/pid_is_pkg.sv
// pid_is_pkg: shared widths, reset values and register indexes for the
// positional pid block with integral separation. no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pid_is_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int GAIN_FRAC_DEF  = 16;

  localparam int GAIN_W      = 32;
  localparam int TICK_W      = 32;
  localparam int INT_W       = 32;
  localparam int LIMIT_W     = 31;
  localparam int THRESH_W    = 17;
  localparam int OUT_LIMIT_W = 15;
  localparam int DRIVE_W     = 16;
  localparam int DIGIT_W     = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0]     INT_LIMIT_RST  = LIMIT_W'(10000);
  localparam logic [THRESH_W-1:0]    SEP_THRESH_RST = THRESH_W'(3000);
  localparam logic [OUT_LIMIT_W-1:0] OUT_LIMIT_RST  = OUT_LIMIT_W'(32767);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P_GAIN     = 3'd0,
    CFG_I_GAIN     = 3'd1,
    CFG_D_GAIN     = 3'd2,
    CFG_INT_LIMIT  = 3'd3,
    CFG_SEP_THRESH = 3'd4,
    CFG_OUT_LIMIT  = 3'd5,
    CFG_SEP_MODE   = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

### hdl/pid_is_if.sv
// pid_is_if: valid/ready stream interfaces for the pid block, one for the
// measurement channel and one for the drive channel. depends on pid_is_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pid_is_in_if #(
  parameter int DATA_WIDTH = pid_is_pkg::DATA_WIDTH_DEF
);
  logic                                valid;
  logic                                ready;
  logic signed [DATA_WIDTH-1:0]        measured;
  logic signed [DATA_WIDTH-1:0]        target;
  logic [pid_is_pkg::TICK_W-1:0]       now_ticks;

  modport source (output valid, measured, target, now_ticks, input ready);
  modport sink   (input valid, measured, target, now_ticks, output ready);
endinterface

interface pid_is_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [pid_is_pkg::DRIVE_W-1:0] drive;
  logic                                clamped;

  modport source (output valid, drive, clamped, input ready);
  modport sink   (input valid, drive, clamped, output ready);
endinterface

`default_nettype wire

### hdl/positional_pid_integral_separation.sv
// positional pid controller with clamp or separation anti-windup.
// depends on pid_is_pkg and the stream interfaces in pid_is_if.
//
//   channel  direction  handshake        payload
//   in_if    sink       valid / ready    measured, target, now_ticks
//   out_if   source     valid / ready    drive, clamped
//   cfg      input      cfg_we_i         cfg_idx_i, cfg_data_i
//
// each transaction is sequenced in steps: a restoring divider retires one
// quotient bit per cycle for the derivative, then one 32x16 multiplier is
// reused for the digits of each of the three terms (two at the default width),
// with a product step and an accumulate step per digit.
// in_if.ready is high only while idle; a finished result waits in the output
// register and the sequencer holds in its last step until that register frees.
// rst_ni clears the controller state and loads register reset values.
`timescale 1ns / 1ps
`default_nettype none

module positional_pid_integral_separation #(
  parameter int DATA_WIDTH     = pid_is_pkg::DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = pid_is_pkg::GAIN_FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pid_is_in_if.sink                         in_if,
  pid_is_out_if.source                      out_if,
  input  logic                              cfg_we_i,
  input  logic [pid_is_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pid_is_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pid_is_pkg::*;

  localparam int ERR_W     = DATA_WIDTH + 1;
  localparam int DIFF_W    = DATA_WIDTH + 2;
  localparam int NUM_W     = DATA_WIDTH + 9;
  localparam int OP_W      = (NUM_W > INT_W) ? NUM_W : INT_W;
  localparam int NDIG      = (OP_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIG_CNT_W = $clog2(NDIG);
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int ACC_W     = OP_W + 43;
  localparam int SH        = GAIN_FRAC_BITS + 8;
  localparam int Q_W       = ACC_W - SH;
  localparam int PROD_W    = GAIN_W + DIGIT_W;
  localparam int SHAMT_W   = $clog2(8 + DIGIT_W * NDIG + 1);

  localparam logic signed [INT_W-1:0] INT_POS_MAX = {1'b0, {(INT_W-1){1'b1}}};
  localparam logic signed [INT_W-1:0] INT_NEG_MAX = {1'b1, {(INT_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIV, ST_INT_SEL, ST_INT_ADD,
    ST_LOAD, ST_MUL, ST_ADD, ST_NORM, ST_FIN
  } state_e;

  typedef enum logic [1:0] {TERM_P, TERM_I, TERM_D} term_e;

  // configuration
  logic [GAIN_W-1:0]      p_gain_q, i_gain_q, d_gain_q;
  logic [LIMIT_W-1:0]     int_limit_q;
  logic [THRESH_W-1:0]    sep_thresh_q;
  logic [OUT_LIMIT_W-1:0] out_limit_q;
  logic                   sep_mode_q;

  // controller state
  state_e                    state_q;
  logic signed [DIFF_W-1:0]  last_err_q;
  logic signed [INT_W-1:0]   integral_q;
  logic [TICK_W-1:0]         last_tick_q;

  // working registers
  logic signed [ERR_W-1:0]   err_q;
  logic [TICK_W-1:0]         elapsed_q;
  logic                      diff_neg_q;
  logic [NUM_W-1:0]          quo_q;
  logic [TICK_W-1:0]         rem_q;
  logic [DIV_CNT_W-1:0]      div_cnt_q;
  logic signed [INT_W-1:0]   int_base_q;
  logic                      int_add_q;
  term_e                     term_q;
  logic [DIG_CNT_W-1:0]      dig_q;
  logic [OP_W-1:0]           opmag_q;
  logic                      opneg_q;
  logic [SHAMT_W-1:0]        shamt_q;
  logic [PROD_W-1:0]         prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]          mag_q;
  logic                      neg_q;

  // output register
  logic                      out_valid_q;
  logic signed [DRIVE_W-1:0] drive_q;
  logic                      clamped_q;

  logic                      in_accept;
  logic                      out_free;
  logic signed [ERR_W-1:0]   err_d;
  logic [TICK_W-1:0]         elapsed_raw;
  logic [TICK_W-1:0]         elapsed_d;
  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic [TICK_W:0]           rem_sh;
  logic [TICK_W:0]           rem_sub;
  logic                      rem_ge;
  logic [ERR_W-1:0]          err_mag;
  logic                      err_neg;
  logic                      err_pos;
  logic signed [INT_W-1:0]   lim;
  logic signed [INT_W-1:0]   nlim;
  logic                      int_over;
  logic                      int_under;
  logic                      err_within;
  logic signed [INT_W:0]     int_sum;
  logic signed [INT_W-1:0]   int_sat;
  logic [INT_W-1:0]          int_mag;
  logic [GAIN_W-1:0]         gain_sel;
  logic [PROD_W-1:0]         prod_d;
  logic [ACC_W-1:0]          term_add;
  logic [Q_W-1:0]            q_hi;
  logic                      q_over;
  logic [OUT_LIMIT_W-1:0]    q_val;
  logic signed [DRIVE_W-1:0] drive_d;

  assign in_if.ready    = (state_q == ST_IDLE);
  assign in_accept      = in_if.valid && in_if.ready;
  assign out_if.valid   = out_valid_q;
  assign out_if.drive   = drive_q;
  assign out_if.clamped = clamped_q;
  assign out_free       = !out_valid_q || out_if.ready;

  always_comb begin
    err_d       = ERR_W'(in_if.target) - ERR_W'(in_if.measured);
    elapsed_raw = in_if.now_ticks - last_tick_q;
    elapsed_d   = (elapsed_raw == '0) ? TICK_W'(1) : elapsed_raw;

    diff     = DIFF_W'(err_q) - last_err_q;
    diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // one restoring division step
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, elapsed_q};
    rem_ge  = (rem_sh >= {1'b0, elapsed_q});

    err_neg    = err_q[ERR_W-1];
    err_pos    = !err_q[ERR_W-1] && (err_q != '0);
    err_mag    = err_neg ? ERR_W'(-err_q) : ERR_W'(err_q);
    lim        = $signed({1'b0, int_limit_q});
    nlim       = -lim;
    int_over   = (integral_q > lim);
    int_under  = (integral_q < nlim);
    err_within = (INT_W'(err_mag) <= INT_W'(sep_thresh_q));

    int_sum = (INT_W+1)'(int_base_q) + (INT_W+1)'(err_q);
    if (int_sum[INT_W] != int_sum[INT_W-1]) begin
      int_sat = int_sum[INT_W] ? INT_NEG_MAX : INT_POS_MAX;
    end else begin
      int_sat = int_sum[INT_W-1:0];
    end
    int_mag = integral_q[INT_W-1] ? INT_W'(-integral_q) : INT_W'(integral_q);

    case (term_q)
      TERM_P:  gain_sel = p_gain_q;
      TERM_I:  gain_sel = i_gain_q;
      TERM_D:  gain_sel = d_gain_q;
      default: gain_sel = '0;
    endcase

    prod_d   = gain_sel * opmag_q[DIGIT_W-1:0];
    term_add = ACC_W'(prod_q) << shamt_q;

    // truncate toward zero, then clamp the magnitude
    q_hi    = mag_q[ACC_W-1:SH];
    q_over  = (q_hi > Q_W'(out_limit_q));
    q_val   = q_over ? out_limit_q : q_hi[OUT_LIMIT_W-1:0];
    drive_d = neg_q ? -DRIVE_W'(q_val) : DRIVE_W'(q_val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q     <= '0;
      i_gain_q     <= '0;
      d_gain_q     <= '0;
      int_limit_q  <= INT_LIMIT_RST;
      sep_thresh_q <= SEP_THRESH_RST;
      out_limit_q  <= OUT_LIMIT_RST;
      sep_mode_q   <= 1'b0;
      state_q      <= ST_IDLE;
      last_err_q   <= '0;
      integral_q   <= '0;
      last_tick_q  <= '0;
      err_q        <= '0;
      elapsed_q    <= '0;
      diff_neg_q   <= 1'b0;
      quo_q        <= '0;
      rem_q        <= '0;
      div_cnt_q    <= '0;
      int_base_q   <= '0;
      int_add_q    <= 1'b0;
      term_q       <= TERM_P;
      dig_q        <= '0;
      opmag_q      <= '0;
      opneg_q      <= 1'b0;
      shamt_q      <= '0;
      prod_q       <= '0;
      acc_q        <= '0;
      mag_q        <= '0;
      neg_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      drive_q      <= '0;
      clamped_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_P_GAIN:     p_gain_q     <= cfg_data_i;
          CFG_I_GAIN:     i_gain_q     <= cfg_data_i;
          CFG_D_GAIN:     d_gain_q     <= cfg_data_i;
          CFG_INT_LIMIT:  int_limit_q  <= cfg_data_i[LIMIT_W-1:0];
          CFG_SEP_THRESH: sep_thresh_q <= cfg_data_i[THRESH_W-1:0];
          CFG_OUT_LIMIT:  out_limit_q  <= cfg_data_i[OUT_LIMIT_W-1:0];
          CFG_SEP_MODE:   sep_mode_q   <= cfg_data_i[0];
          default: ;
        endcase
      end

      // in the finish step a departing result is replaced by the new one
      if (out_if.valid && out_if.ready && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            err_q       <= err_d;
            elapsed_q   <= elapsed_d;
            last_tick_q <= in_if.now_ticks;
            state_q     <= ST_PREP;
          end
        end
        ST_PREP: begin
          diff_neg_q <= diff[DIFF_W-1];
          quo_q      <= {diff_mag[DIFF_W-2:0], 8'b0};
          rem_q      <= '0;
          div_cnt_q  <= '0;
          last_err_q <= DIFF_W'(err_q);
          state_q    <= ST_DIV;
        end
        ST_DIV: begin
          rem_q     <= rem_ge ? rem_sub[TICK_W-1:0] : rem_sh[TICK_W-1:0];
          quo_q     <= {quo_q[NUM_W-2:0], rem_ge};
          div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
          if (div_cnt_q == DIV_CNT_W'(NUM_W - 1)) begin
            state_q <= ST_INT_SEL;
          end
        end
        ST_INT_SEL: begin
          if (!sep_mode_q) begin
            int_add_q <= 1'b1;
            if (int_over) begin
              int_base_q <= lim;
            end else if (int_under) begin
              int_base_q <= nlim;
            end else begin
              int_base_q <= integral_q;
            end
          end else begin
            int_base_q <= integral_q;
            // beyond the limit only errors that pull back toward zero count
            if (int_over) begin
              int_add_q <= err_within && err_neg;
            end else if (int_under) begin
              int_add_q <= err_within && err_pos;
            end else begin
              int_add_q <= err_within;
            end
          end
          state_q <= ST_INT_ADD;
        end
        ST_INT_ADD: begin
          integral_q <= int_add_q ? int_sat : int_base_q;
          term_q     <= TERM_P;
          acc_q      <= '0;
          state_q    <= ST_LOAD;
        end
        ST_LOAD: begin
          dig_q <= '0;
          case (term_q)
            TERM_P: begin
              opmag_q <= OP_W'(err_mag);
              opneg_q <= err_neg;
              shamt_q <= SHAMT_W'(8);
            end
            TERM_I: begin
              opmag_q <= OP_W'(int_mag);
              opneg_q <= integral_q[INT_W-1];
              shamt_q <= SHAMT_W'(8);
            end
            TERM_D: begin
              opmag_q <= OP_W'(quo_q);
              opneg_q <= diff_neg_q;
              shamt_q <= '0;
            end
            default: begin
              opmag_q <= '0;
              opneg_q <= 1'b0;
              shamt_q <= '0;
            end
          endcase
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          prod_q  <= prod_d;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          acc_q   <= opneg_q ? acc_q - term_add : acc_q + term_add;
          opmag_q <= opmag_q >> DIGIT_W;
          shamt_q <= shamt_q + SHAMT_W'(DIGIT_W);
          dig_q   <= dig_q + DIG_CNT_W'(1);
          if (dig_q == DIG_CNT_W'(NDIG - 1)) begin
            case (term_q)
              TERM_P: begin
                term_q  <= TERM_I;
                state_q <= ST_LOAD;
              end
              TERM_I: begin
                term_q  <= TERM_D;
                state_q <= ST_LOAD;
              end
              default: state_q <= ST_NORM;
            endcase
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_NORM: begin
          neg_q   <= acc_q[ACC_W-1];
          mag_q   <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            drive_q     <= drive_d;
            clamped_q   <= q_over;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### test/positional_pid_integral_separation_tb.sv
// testbench for positional_pid_integral_separation: directed and random
// measurement transactions, self-checking against an in-bench pid predictor.
// depends on pid_is_pkg, pid_is_if and the block itself.
`timescale 1ns / 1ps

module positional_pid_integral_separation_tb;
  import pid_is_pkg::*;

  localparam int DW   = DATA_WIDTH_DEF;
  localparam int FRAC = GAIN_FRAC_DEF;
  // no register lives at this index, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef struct packed {
    logic signed [DW-1:0] measured;
    logic signed [DW-1:0] target;
    logic [TICK_W-1:0]    now_ticks;
  } sample_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clamped;
  } drive_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pid_is_in_if #(.DATA_WIDTH(DW)) in_bus ();
  pid_is_out_if out_bus ();

  positional_pid_integral_separation #(
    .DATA_WIDTH    (DW),
    .GAIN_FRAC_BITS(FRAC)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  sample_t    pending_samples[$];
  drive_rec_t expected_drives[$];
  int         mismatches = 0;
  int         drives_seen = 0;

  // controller copy: registers and loop state
  logic [GAIN_W-1:0]      kp, ki, kd;
  logic [LIMIT_W-1:0]     windup_limit;
  logic [THRESH_W-1:0]    sep_threshold;
  logic [OUT_LIMIT_W-1:0] drive_limit;
  logic                   sep_mode;
  longint                 prev_error;
  longint                 integ;
  logic [TICK_W-1:0]      prev_tick;

  function automatic longint clip_to_int32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic drive_rec_t pid_update(input sample_t s);
    logic [TICK_W-1:0]     dt;
    longint                err, diff, slope_mag, slope, lim, acc;
    logic signed [127:0]   gp, gi, gd, e_w, a_w, c_w, total, mag;
    logic [127:0]          q;
    logic [DRIVE_W-1:0]    lvl;
    drive_rec_t            r;
    dt = s.now_ticks - prev_tick;
    if (dt == '0) dt = 1;
    err = longint'(s.target) - longint'(s.measured);
    diff = err - prev_error;
    slope_mag = ((diff < 0 ? -diff : diff) << 8) / longint'(dt);
    slope = diff < 0 ? -slope_mag : slope_mag;
    prev_error = err;
    prev_tick = s.now_ticks;

    lim = longint'(windup_limit);
    acc = integ;
    if (!sep_mode) begin
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      acc = clip_to_int32(acc + err);
    end else if ((err < 0 ? -err : err) <= longint'(sep_threshold)) begin
      // outside the limit only errors that pull back toward zero count
      if (acc > lim) begin
        if (err < 0) acc = clip_to_int32(acc + err);
      end else if (acc < -lim) begin
        if (err > 0) acc = clip_to_int32(acc + err);
      end else begin
        acc = clip_to_int32(acc + err);
      end
    end
    integ = acc;

    gp = {96'd0, kp};
    gi = {96'd0, ki};
    gd = {96'd0, kd};
    e_w = err;
    a_w = acc;
    c_w = slope;
    total = ((gp * e_w + gi * a_w) <<< 8) + gd * c_w;
    mag = total < 0 ? -total : total;
    q = mag >> (FRAC + 8);
    r.clamped = q > 128'(drive_limit);
    if (r.clamped) q = 128'(drive_limit);
    lvl = q[DRIVE_W-1:0];
    r.drive = total < 0 ? -lvl : lvl;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_P_GAIN:     kp = val;
      CFG_I_GAIN:     ki = val;
      CFG_D_GAIN:     kd = val;
      CFG_INT_LIMIT:  windup_limit = val[LIMIT_W-1:0];
      CFG_SEP_THRESH: sep_threshold = val[THRESH_W-1:0];
      CFG_OUT_LIMIT:  drive_limit = val[OUT_LIMIT_W-1:0];
      CFG_SEP_MODE:   sep_mode = val[0];
      default: ;
    endcase
  endtask

  task automatic queue_sample(input int msr, input int tgt, input logic [TICK_W-1:0] tk);
    sample_t s;
    s.measured  = msr[DW-1:0];
    s.target    = tgt[DW-1:0];
    s.now_ticks = tk;
    pending_samples.push_back(s);
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_bus.valid || expected_drives.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // sender: bursts of measurement transactions separated by random gaps
  int burst_left, gap_left;

  always @(posedge clk_i) begin : sender
    sample_t s;
    if (!rst_ni) begin
      in_bus.valid     <= 1'b0;
      in_bus.measured  <= '0;
      in_bus.target    <= '0;
      in_bus.now_ticks <= '0;
      burst_left       <= 1;
      gap_left         <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        s.measured  = in_bus.measured;
        s.target    = in_bus.target;
        s.now_ticks = in_bus.now_ticks;
        expected_drives.push_back(pid_update(s));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          s = pending_samples.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.measured  <= s.measured;
          in_bus.target    <= s.target;
          in_bus.now_ticks <= s.now_ticks;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 8);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks drive transactions and stalls in random stretches
  int ready_left;

  always @(posedge clk_i) begin : receiver
    drive_rec_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      ready_left    <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        drives_seen++;
        if (expected_drives.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive transaction %0d with nothing pending: drive %0d clamped %0b",
                     drives_seen, out_bus.drive, out_bus.clamped);
        end else begin
          want = expected_drives.pop_front();
          if (out_bus.drive !== want.drive || out_bus.clamped !== want.clamped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("drive transaction %0d: expected %0d/%0b, got %0d/%0b",
                       drives_seen, want.drive, want.clamped, out_bus.drive,
                       out_bus.clamped);
          end
        end
      end
      if (ready_left != 0) begin
        ready_left <= ready_left - 1;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_bus.ready <= 1'b0;
            ready_left    <= $urandom_range(0, 50);
          end
          3: begin
            out_bus.ready <= 1'b1;
            ready_left    <= 400;
          end
          default: begin
            out_bus.ready <= 1'b1;
            ready_left    <= $urandom_range(0, 30);
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [TICK_W-1:0] tick_gen;
    int tgt, msr, mag;
    int sep_errs[11];
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    in_bus.valid     = 1'b0;
    in_bus.measured  = '0;
    in_bus.target    = '0;
    in_bus.now_ticks = '0;
    out_bus.ready    = 1'b0;
    kp = '0;
    ki = '0;
    kd = '0;
    windup_limit  = INT_LIMIT_RST;
    sep_threshold = SEP_THRESH_RST;
    drive_limit   = OUT_LIMIT_RST;
    sep_mode      = 1'b0;
    prev_error    = 0;
    integ         = 0;
    prev_tick     = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values, zero error keeps the integral at zero
    queue_sample(1234, 1234, 0);
    queue_sample(-77, -77, 1);
    wait_drained();

    // separation mode around threshold and limit edges
    write_reg(CFG_P_GAIN, 32'h0001_0000);
    write_reg(CFG_I_GAIN, 32'h0001_0000);
    write_reg(CFG_D_GAIN, 32'h0000_0000);
    write_reg(CFG_INT_LIMIT, 32'd1000);
    write_reg(CFG_SEP_THRESH, 32'd3000);
    write_reg(CFG_OUT_LIMIT, 32'd32767);
    write_reg(CFG_SEP_MODE, 32'd1);
    sep_errs = '{3001, 3000, 100, -3001, -1500, -500, 10, -2010, -5, -5, 5};
    tick_gen = 2;
    foreach (sep_errs[k]) begin
      tick_gen++;
      queue_sample(0, sep_errs[k], tick_gen);
    end
    wait_drained();

    // clamp mode with full-scale errors, zero elapsed time and tick wrap
    write_reg(CFG_I_GAIN, 32'h0000_0100);
    write_reg(CFG_D_GAIN, 32'h0000_4000);
    write_reg(CFG_INT_LIMIT, 32'd10000);
    write_reg(CFG_SEP_THRESH, 32'd131071);
    write_reg(CFG_SEP_MODE, 32'd0);
    queue_sample(-32768, 32767, tick_gen);
    queue_sample(32767, -32768, tick_gen + 1);
    queue_sample(100, 103, tick_gen + 4);
    queue_sample(100, 98, tick_gen + 7);
    queue_sample(-500, 600, 32'hFFFF_FFF0);
    queue_sample(20, -20, 32'h0000_0005);
    queue_sample(0, 0, 32'h0000_0005);
    wait_drained();

    // full gains and limits, zero drive limit written through the mask
    write_reg(CFG_P_GAIN, 32'hFFFF_FFFF);
    write_reg(CFG_I_GAIN, 32'hFFFF_FFFF);
    write_reg(CFG_D_GAIN, 32'hFFFF_FFFF);
    write_reg(CFG_INT_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_SEP_THRESH, 32'hFFFF_FFFF);
    write_reg(CFG_OUT_LIMIT, 32'h0000_8000);
    queue_sample(10, -9000, 6);
    queue_sample(-32768, 32767, 9);
    wait_drained();

    // zero gains and limits, mode and drive limit set through the mask
    write_reg(CFG_P_GAIN, 32'h0);
    write_reg(CFG_I_GAIN, 32'h0);
    write_reg(CFG_D_GAIN, 32'h0);
    write_reg(CFG_INT_LIMIT, 32'h0);
    write_reg(CFG_SEP_THRESH, 32'h0);
    write_reg(CFG_OUT_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_SEP_MODE, 32'hFFFF_FFFF);
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    queue_sample(5, 5, 10);
    queue_sample(0, 5, 11);
    wait_drained();
    tick_gen = 11;
    tgt = 0;

    repeat (9) begin
      case ($urandom_range(0, 5))
        0: write_reg(CFG_P_GAIN, 32'h0);
        1: write_reg(CFG_P_GAIN, 32'hFFFF_FFFF);
        2: write_reg(CFG_P_GAIN, $urandom);
        default: write_reg(CFG_P_GAIN, $urandom_range(0, 32'h4_0000));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CFG_I_GAIN, 32'h0);
        1: write_reg(CFG_I_GAIN, $urandom);
        default: write_reg(CFG_I_GAIN, $urandom_range(0, 32'h2000));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CFG_D_GAIN, 32'h0);
        1: write_reg(CFG_D_GAIN, $urandom);
        default: write_reg(CFG_D_GAIN, $urandom_range(0, 32'h8_0000));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CFG_INT_LIMIT, 32'h0);
        1: write_reg(CFG_INT_LIMIT, $urandom);
        default: write_reg(CFG_INT_LIMIT, $urandom_range(0, 20000));
      endcase
      case ($urandom_range(0, 4))
        0: write_reg(CFG_SEP_THRESH, 32'h0);
        1: write_reg(CFG_SEP_THRESH, $urandom);
        default: write_reg(CFG_SEP_THRESH, $urandom_range(0, 5000));
      endcase
      case ($urandom_range(0, 5))
        0: write_reg(CFG_OUT_LIMIT, 32'h0);
        1: write_reg(CFG_OUT_LIMIT, $urandom);
        2: write_reg(CFG_OUT_LIMIT, 32'd32767);
        default: write_reg(CFG_OUT_LIMIT, $urandom_range(1, 32767));
      endcase
      write_reg(CFG_SEP_MODE, $urandom);

      repeat (50) begin
        if ($urandom_range(0, 9) < 7) begin
          // closed-loop style: measurement near a slowly moving target
          if ($urandom_range(0, 7) == 0) tgt = int'($urandom_range(0, 65535)) - 32768;
          case ($urandom_range(0, 2))
            0: mag = $urandom_range(0, 200);
            1: mag = $urandom_range(0, 6000);
            default: mag = $urandom_range(0, 65535);
          endcase
          msr = $urandom_range(0, 1) ? tgt - mag : tgt + mag;
          if (msr > 32767) msr = 32767;
          if (msr < -32768) msr = -32768;
          tick_gen += $urandom_range(0, 4);
          queue_sample(msr, tgt, tick_gen);
        end else begin
          tick_gen = $urandom;
          queue_sample($urandom, $urandom, tick_gen);
        end
      end
      wait_drained();
    end

    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_drives.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/pid_is_pkg.sv
hdl/pid_is_if.sv
hdl/positional_pid_integral_separation.sv
test/positional_pid_integral_separation_tb.sv
